/* hw/rtl/vfr_pkg.sv */
// ---------------------------------------------------------------------------
// vfr_pkg: shared types and constants of the volume fade ramp
// item formats, command and fade codes, csr indexes and clamp helpers
// ---------------------------------------------------------------------------
package vfr_pkg;

   localparam int LEVEL_BITS    = 8;
   localparam int DURATION_BITS = 16;
   localparam int OP_BITS       = 3;
   localparam int DIR_BITS      = 2;
   localparam int COUNT_BITS    = 9;
   localparam int CSR_IDX_BITS  = 2;
   localparam int DIV_CNT_BITS  = $clog2(DURATION_BITS + 1);

   localparam logic [COUNT_BITS-1:0] COUNT_MAX   = {COUNT_BITS{1'b1}};
   localparam logic [COUNT_BITS-1:0] INTERVAL_LO = COUNT_BITS'(10);
   localparam logic [COUNT_BITS-1:0] INTERVAL_HI = COUNT_BITS'(500);

   // command codes
   localparam logic [OP_BITS-1:0] OP_TICK       = 3'd0;
   localparam logic [OP_BITS-1:0] OP_SET_VOLUME = 3'd1;
   localparam logic [OP_BITS-1:0] OP_FADE_IN    = 3'd2;
   localparam logic [OP_BITS-1:0] OP_FADE_OUT   = 3'd3;
   localparam logic [OP_BITS-1:0] OP_FADE_TO    = 3'd4;
   localparam logic [OP_BITS-1:0] OP_STOP_FADE  = 3'd5;

   // fade direction codes
   localparam logic [DIR_BITS-1:0] FADE_NONE = 2'd0;
   localparam logic [DIR_BITS-1:0] FADE_IN   = 2'd1;
   localparam logic [DIR_BITS-1:0] FADE_OUT  = 2'd2;

   // csr register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_VOLUME_MIN  = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_VOLUME_MAX  = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_FADE_MIN_MS = 2'd2;

   // csr reset values
   localparam logic [LEVEL_BITS-1:0]    VOLUME_MIN_RST  = LEVEL_BITS'(0);
   localparam logic [LEVEL_BITS-1:0]    VOLUME_MAX_RST  = LEVEL_BITS'(30);
   localparam logic [DURATION_BITS-1:0] FADE_MIN_RST    = DURATION_BITS'(100);

   typedef struct packed {
      logic [OP_BITS-1:0]       op;
      logic [LEVEL_BITS-1:0]    level;
      logic [DURATION_BITS-1:0] duration_ms;
      logic                     stop_sound;
   } req_type;

   typedef struct packed {
      logic [LEVEL_BITS-1:0] volume;
      logic                  volume_changed;
      logic [DIR_BITS-1:0]   direction;
      logic                  stop_request;
      logic                  play_request;
      logic                  ignored;
   } rsp_type;

   typedef struct packed {
      logic                     start;
      logic [DURATION_BITS-1:0] dividend;
      logic [LEVEL_BITS-1:0]    divisor;
   } div_ctl_type;

   typedef struct packed {
      logic                     busy;
      logic                     done;
      logic [DURATION_BITS-1:0] quotient;
   } div_sts_type;

   // floor first, then ceiling, so crossed limits resolve to the floor test
   function automatic logic [LEVEL_BITS-1:0] level_clamp(
      input logic [LEVEL_BITS-1:0] x,
      input logic [LEVEL_BITS-1:0] lo,
      input logic [LEVEL_BITS-1:0] hi
   );
      logic [LEVEL_BITS-1:0] r;
      if (x < lo) begin
         r = lo;
      end else if (x > hi) begin
         r = hi;
      end else begin
         r = x;
      end
      return r;
   endfunction

   function automatic logic [COUNT_BITS-1:0] interval_clamp(
      input logic [DURATION_BITS-1:0] q
   );
      logic [COUNT_BITS-1:0] r;
      if (32'(q) < 32'(INTERVAL_LO)) begin
         r = INTERVAL_LO;
      end else if (32'(q) > 32'(INTERVAL_HI)) begin
         r = INTERVAL_HI;
      end else begin
         r = q[COUNT_BITS-1:0];
      end
      return r;
   endfunction

endpackage

/* hw/rtl/volume_fade_ramp_top.sv */
// ---------------------------------------------------------------------------
// volume_fade_ramp_top: linear volume fade ramp controller
// command sequencer with one shared serial divider for the step interval
// ---------------------------------------------------------------------------
// Each request item carries one command: a one-millisecond tick, set volume,
// fade in, fade out, fade to or stop fade. Every item yields exactly one
// response item with the volume, a changed flag, the fade direction and the
// stop, play and ignored pulses. Items are handled one at a time. A fade
// start goes through decode, the serial divider (one quotient bit per cycle
// of the 16-bit duration divided by the level difference), a clamp of the
// quotient into the step interval and the load of the response register.
// Every other command goes through decode and the load. The sequencer is
// back in idle once the response is loaded and can take the next item from
// there. The response register lets the sequencer return to idle as soon
// as its result is loaded, so a new item is accepted while that response
// is still waiting; the next finished item then holds until the register
// drains, for as long as rsp_ready stays low.
// Csr writes (volume_min, volume_max, fade_min_ms) are always taken and
// should only be issued while no item is in flight.
// ---------------------------------------------------------------------------
module volume_fade_ramp_top (
   input  logic                                 clock,
   input  logic                                 reset,
   // request channel
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  vfr_pkg::req_type                     req_data,
   // response channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output vfr_pkg::rsp_type                     rsp_data,
   // csr write channel
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [vfr_pkg::CSR_IDX_BITS-1:0]     csr_index,
   input  logic [vfr_pkg::DURATION_BITS-1:0]    csr_data
);

   // sequencer states
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_EXEC = 2'd1;
   localparam logic [1:0] ST_DIV  = 2'd2;
   localparam logic [1:0] ST_DONE = 2'd3;

   localparam int LB = vfr_pkg::LEVEL_BITS;
   localparam int DB = vfr_pkg::DURATION_BITS;
   localparam int CB = vfr_pkg::COUNT_BITS;

   // csr registers
   logic [LB-1:0] vol_min_ff;
   logic [LB-1:0] vol_max_ff;
   logic [DB-1:0] fade_min_ff;

   // sequencer and item holding
   logic [1:0]       state_ff, state_in;
   vfr_pkg::req_type item_ff, item_in;

   // architectural fade state
   logic [LB-1:0]               cur_ff, cur_in;
   logic [LB-1:0]               goal_ff, goal_in;
   logic [vfr_pkg::DIR_BITS-1:0] fade_ff, fade_in;
   logic [CB-1:0]               interval_ff, interval_in;
   logic [CB-1:0]               since_ff, since_in;
   logic                        stop_after_ff, stop_after_in;

   // pending result bookkeeping
   logic [LB-1:0]               before_ff, before_in;
   logic [vfr_pkg::DIR_BITS-1:0] dir_ff, dir_in;
   logic                        stop_ff, stop_in;
   logic                        play_ff, play_in;
   logic                        ign_ff, ign_in;

   // response register
   logic             rsp_valid_ff, rsp_valid_in;
   vfr_pkg::rsp_type rsp_ff, rsp_in;

   // shared divider
   vfr_pkg::div_ctl_type div_ctl;
   vfr_pkg::div_sts_type div_sts;

   // decode temporaries
   logic [LB-1:0]               cur_a;
   logic [LB-1:0]               goal_a;
   logic [LB-1:0]               diff_a;
   logic [DB-1:0]               dur_a;
   logic                        go;
   logic [vfr_pkg::DIR_BITS-1:0] go_dir;
   logic [CB-1:0]               since_inc;
   logic [LB:0]                 up_lvl;
   logic [LB-1:0]               nv;
   logic [LB-1:0]               stepped;

   assign csr_ready = 1'b1;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   vfr_div u_div (
      .clock (clock),
      .reset (reset),
      .ctl   (div_ctl),
      .sts   (div_sts)
   );

   always_comb begin
      state_in      = state_ff;
      item_in       = item_ff;
      cur_in        = cur_ff;
      goal_in       = goal_ff;
      fade_in       = fade_ff;
      interval_in   = interval_ff;
      since_in      = since_ff;
      stop_after_in = stop_after_ff;
      before_in     = before_ff;
      dir_in        = dir_ff;
      stop_in       = stop_ff;
      play_in       = play_ff;
      ign_in        = ign_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_in        = rsp_ff;

      // fade in always restarts from the floor, other requests from current
      if (item_ff.op == vfr_pkg::OP_FADE_IN) begin
         cur_a = vfr_pkg::level_clamp('0, vol_min_ff, vol_max_ff);
      end else begin
         cur_a = vfr_pkg::level_clamp(cur_ff, vol_min_ff, vol_max_ff);
      end
      goal_a = vfr_pkg::level_clamp(item_ff.level, vol_min_ff, vol_max_ff);
      diff_a = (goal_a > cur_a) ? (goal_a - cur_a) : (cur_a - goal_a);
      dur_a  = (item_ff.duration_ms < fade_min_ff) ? fade_min_ff : item_ff.duration_ms;
      go     = 1'b0;
      go_dir = vfr_pkg::FADE_NONE;

      // one ramp step
      since_inc = (since_ff == vfr_pkg::COUNT_MAX) ? since_ff : (since_ff + 1'b1);
      up_lvl    = {1'b0, cur_ff} + 1'b1;
      if (fade_ff == vfr_pkg::FADE_IN) begin
         nv = (up_lvl > {1'b0, goal_ff}) ? goal_ff : up_lvl[LB-1:0];
      end else if (fade_ff == vfr_pkg::FADE_OUT) begin
         nv = ((cur_ff == '0) || ((cur_ff - 1'b1) < goal_ff)) ? goal_ff
              : (cur_ff - 1'b1);
      end else begin
         nv = cur_ff;
      end
      stepped = vfr_pkg::level_clamp(nv, vol_min_ff, vol_max_ff);

      div_ctl.start    = 1'b0;
      div_ctl.dividend = dur_a;
      div_ctl.divisor  = diff_a;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               item_in  = req_data;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            before_in = cur_ff;
            stop_in   = 1'b0;
            play_in   = 1'b0;
            ign_in    = 1'b0;
            state_in  = ST_DONE;
            case (item_ff.op)
               vfr_pkg::OP_TICK: begin
                  if (fade_ff != vfr_pkg::FADE_NONE) begin
                     if (since_inc >= interval_ff) begin
                        since_in = '0;
                        cur_in   = stepped;
                        if (stepped == goal_ff) begin
                           if ((fade_ff == vfr_pkg::FADE_OUT) && stop_after_ff) begin
                              stop_in       = 1'b1;
                              stop_after_in = 1'b0;
                           end
                           fade_in = vfr_pkg::FADE_NONE;
                        end
                     end else begin
                        since_in = since_inc;
                     end
                  end
               end
               vfr_pkg::OP_SET_VOLUME: begin
                  cur_in = goal_a;
               end
               vfr_pkg::OP_FADE_IN: begin
                  cur_in  = cur_a;
                  play_in = 1'b1;
                  if (fade_ff == vfr_pkg::FADE_NONE) begin
                     goal_in = goal_a;
                     go      = (diff_a != '0);
                     go_dir  = vfr_pkg::FADE_IN;
                  end else begin
                     ign_in = 1'b1;
                  end
               end
               vfr_pkg::OP_FADE_OUT: begin
                  stop_after_in = item_ff.stop_sound;
                  if (fade_ff == vfr_pkg::FADE_NONE) begin
                     cur_in  = cur_a;
                     goal_in = goal_a;
                     go      = (cur_a > goal_a);
                     go_dir  = vfr_pkg::FADE_OUT;
                  end else begin
                     ign_in = 1'b1;
                  end
               end
               vfr_pkg::OP_FADE_TO: begin
                  stop_after_in = 1'b0;
                  if (fade_ff == vfr_pkg::FADE_NONE) begin
                     cur_in  = cur_a;
                     goal_in = goal_a;
                     go      = (diff_a != '0);
                     go_dir  = (cur_a < goal_a) ? vfr_pkg::FADE_IN : vfr_pkg::FADE_OUT;
                  end else begin
                     ign_in = 1'b1;
                  end
               end
               vfr_pkg::OP_STOP_FADE: begin
                  if (fade_ff != vfr_pkg::FADE_NONE) begin
                     stop_in       = (fade_ff == vfr_pkg::FADE_OUT) && item_ff.stop_sound;
                     fade_in       = vfr_pkg::FADE_NONE;
                     interval_in   = '0;
                     since_in      = '0;
                     stop_after_in = 1'b0;
                  end
               end
               default: begin
                  // unused codes leave the state alone
               end
            endcase
            // fade start: interval comes from the divider
            if (go) begin
               div_ctl.start = 1'b1;
               dir_in        = go_dir;
               state_in      = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_sts.done) begin
               interval_in = vfr_pkg::interval_clamp(div_sts.quotient);
               since_in    = '0;
               fade_in     = dir_ff;
               state_in    = ST_DONE;
            end
         end
         ST_DONE: begin
            // load the response once the output slot is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in          = 1'b1;
               rsp_in.volume         = cur_ff;
               rsp_in.volume_changed = (cur_ff != before_ff);
               rsp_in.direction      = fade_ff;
               rsp_in.stop_request   = stop_ff;
               rsp_in.play_request   = play_ff;
               rsp_in.ignored        = ign_ff;
               state_in              = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control and architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         cur_ff        <= '0;
         goal_ff       <= '0;
         fade_ff       <= vfr_pkg::FADE_NONE;
         interval_ff   <= '0;
         since_ff      <= '0;
         stop_after_ff <= 1'b0;
         vol_min_ff    <= vfr_pkg::VOLUME_MIN_RST;
         vol_max_ff    <= vfr_pkg::VOLUME_MAX_RST;
         fade_min_ff   <= vfr_pkg::FADE_MIN_RST;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         cur_ff        <= cur_in;
         goal_ff       <= goal_in;
         fade_ff       <= fade_in;
         interval_ff   <= interval_in;
         since_ff      <= since_in;
         stop_after_ff <= stop_after_in;
         // csr writes, unknown indexes dropped
         if (csr_valid) begin
            case (csr_index)
               vfr_pkg::CSR_VOLUME_MIN:  vol_min_ff  <= csr_data[LB-1:0];
               vfr_pkg::CSR_VOLUME_MAX:  vol_max_ff  <= csr_data[LB-1:0];
               vfr_pkg::CSR_FADE_MIN_MS: fade_min_ff <= csr_data;
               default: begin
               end
            endcase
         end
      end
   end

   // payload holding, no reset needed
   always_ff @(posedge clock) begin
      item_ff   <= item_in;
      before_ff <= before_in;
      dir_ff    <= dir_in;
      stop_ff   <= stop_in;
      play_ff   <= play_in;
      ign_ff    <= ign_in;
      rsp_ff    <= rsp_in;
   end

   // a running fade always has a clamped interval
   a_interval_range: assert property (@(posedge clock) disable iff (reset)
      (fade_ff != vfr_pkg::FADE_NONE) |->
         ((interval_ff >= vfr_pkg::INTERVAL_LO) && (interval_ff <= vfr_pkg::INTERVAL_HI)))
      else $error("fade running with interval out of range");

   // step counter stays below the interval while fading
   a_since_below: assert property (@(posedge clock) disable iff (reset)
      (fade_ff != vfr_pkg::FADE_NONE) |-> (since_ff < interval_ff))
      else $error("step counter passed the interval");

   // divider results only arrive while the sequencer waits for them
   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_sts.done |-> (state_ff == ST_DIV))
      else $error("divider finished outside the divide state");

   // a finished item always reaches the response register
   a_done_loads: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready)) |=>
         (rsp_valid_ff && (state_ff == ST_IDLE)))
      else $error("finished item not loaded into response register");

endmodule

/* hw/rtl/vfr_div.sv */
// ---------------------------------------------------------------------------
// vfr_div: serial restoring divider
// one quotient bit per cycle, duration by level difference
// ---------------------------------------------------------------------------
module vfr_div (
   input  logic                 clock,
   input  logic                 reset,
   input  vfr_pkg::div_ctl_type ctl,
   output vfr_pkg::div_sts_type sts
);

   logic [vfr_pkg::LEVEL_BITS-1:0]    rem_ff, rem_in;
   logic [vfr_pkg::DURATION_BITS-1:0] quo_ff, quo_in;
   logic [vfr_pkg::LEVEL_BITS-1:0]    dsr_ff, dsr_in;
   logic [vfr_pkg::DIV_CNT_BITS-1:0]  cnt_ff, cnt_in;
   logic                              busy_ff, busy_in;
   logic                              done_ff, done_in;
   logic [vfr_pkg::LEVEL_BITS:0]      shifted;
   logic [vfr_pkg::LEVEL_BITS:0]      diff;

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      shifted = {rem_ff, quo_ff[vfr_pkg::DURATION_BITS-1]};
      diff    = shifted - {1'b0, dsr_ff};
      if (ctl.start) begin
         rem_in  = '0;
         quo_in  = ctl.dividend;
         dsr_in  = ctl.divisor;
         cnt_in  = vfr_pkg::DIV_CNT_BITS'(vfr_pkg::DURATION_BITS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // trial subtract of the shifted partial remainder
         if (shifted >= {1'b0, dsr_ff}) begin
            rem_in = diff[vfr_pkg::LEVEL_BITS-1:0];
            quo_in = {quo_ff[vfr_pkg::DURATION_BITS-2:0], 1'b1};
         end else begin
            rem_in = shifted[vfr_pkg::LEVEL_BITS-1:0];
            quo_in = {quo_ff[vfr_pkg::DURATION_BITS-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == vfr_pkg::DIV_CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign sts.busy     = busy_ff;
   assign sts.done     = done_ff;
   assign sts.quotient = quo_ff;

   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff))
      else $error("divider done without a running division");

   a_no_start_when_busy: assert property (@(posedge clock) disable iff (reset)
      ctl.start |-> !busy_ff)
      else $error("divider restarted while busy");

   a_count_live: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (cnt_ff != '0))
      else $error("divider busy with an exhausted count");

endmodule

/* tb/sv/tb_volume_fade_ramp_top.sv */
// ---------------------------------------------------------------------------
// tb_volume_fade_ramp_top: self-checking bench for the volume fade ramp
// A short command table after reset, some rows with hand-written results,
// then phases of random fade sequences under different clamp and fade
// settings and sender and receiver idling. Each response item is checked
// field by field against its hand-written result or a cycle-free behavioral model.
// ---------------------------------------------------------------------------
module tb_volume_fade_ramp_top;
   timeunit 1ns;
   timeprecision 1ps;

   // spare command codes, decoded as no operation
   localparam logic [vfr_pkg::OP_BITS-1:0] OP_SPARE_6 = 3'd6;
   localparam logic [vfr_pkg::OP_BITS-1:0] OP_SPARE_7 = 3'd7;

   localparam int PHASE_ITEMS   = 16;   // random items per phase
   localparam int TICK_CAP      = 24;   // longest tick run after one fade start
   localparam int LONG_TICKS    = 502;  // one full step at the longest interval
   localparam int SETTLE_CYCLES = 40;   // margin for a fade start to run out
   localparam int MAX_REPORTS   = 10;

   // directed command table; typed rows carry their result, the rest use the model
   typedef struct packed {
      logic [7:0]       count;
      vfr_pkg::req_type cmd;
      logic             typed;
      vfr_pkg::rsp_type result;
   } script_row_type;

   localparam int SCRIPT_LEN = 17;
   localparam script_row_type SCRIPT [SCRIPT_LEN] = '{
      // quiet block right after reset
      '{8'd1, '{vfr_pkg::OP_TICK, 8'd0, 16'd0, 1'b0}, 1'b1,
        '{8'd0, 1'b0, vfr_pkg::FADE_NONE, 1'b0, 1'b0, 1'b0}},
      // set volume far above the ceiling, then back to the floor
      '{8'd1, '{vfr_pkg::OP_SET_VOLUME, 8'd255, 16'd0, 1'b0}, 1'b1,
        '{8'd30, 1'b1, vfr_pkg::FADE_NONE, 1'b0, 1'b0, 1'b0}},
      '{8'd1, '{vfr_pkg::OP_SET_VOLUME, 8'd0, 16'd0, 1'b0}, 1'b1,
        '{8'd0, 1'b1, vfr_pkg::FADE_NONE, 1'b0, 1'b0, 1'b0}},
      // spare codes with every field bit set do nothing
      '{8'd1, '{OP_SPARE_6, 8'd255, 16'hffff, 1'b1}, 1'b1,
        '{8'd0, 1'b0, vfr_pkg::FADE_NONE, 1'b0, 1'b0, 1'b0}},
      '{8'd1, '{OP_SPARE_7, 8'd255, 16'hffff, 1'b1}, 1'b1,
        '{8'd0, 1'b0, vfr_pkg::FADE_NONE, 1'b0, 1'b0, 1'b0}},
      // stop fade with no fade running
      '{8'd1, '{vfr_pkg::OP_STOP_FADE, 8'd0, 16'd0, 1'b1}, 1'b1,
        '{8'd0, 1'b0, vfr_pkg::FADE_NONE, 1'b0, 1'b0, 1'b0}},
      // zero difference starts nothing
      '{8'd1, '{vfr_pkg::OP_FADE_TO, 8'd0, 16'd0, 1'b0}, 1'b1,
        '{8'd0, 1'b0, vfr_pkg::FADE_NONE, 1'b0, 1'b0, 1'b0}},
      '{8'd1, '{vfr_pkg::OP_FADE_OUT, 8'd0, 16'd0, 1'b1}, 1'b1,
        '{8'd0, 1'b0, vfr_pkg::FADE_NONE, 1'b0, 1'b0, 1'b0}},
      // fade in toward the ceiling, duration raised to the minimum
      '{8'd1, '{vfr_pkg::OP_FADE_IN, 8'd255, 16'd0, 1'b0}, 1'b0, '0},
      // fade requests while fading are dropped and flagged
      '{8'd1, '{vfr_pkg::OP_FADE_TO, 8'd5, 16'd0, 1'b0}, 1'b1,
        '{8'd0, 1'b0, vfr_pkg::FADE_IN, 1'b0, 1'b0, 1'b1}},
      '{8'd1, '{vfr_pkg::OP_FADE_IN, 8'd255, 16'hffff, 1'b1}, 1'b1,
        '{8'd0, 1'b0, vfr_pkg::FADE_IN, 1'b0, 1'b1, 1'b1}},
      // first step lands on the tenth tick
      '{8'd10, '{vfr_pkg::OP_TICK, 8'd0, 16'd0, 1'b0}, 1'b0, '0},
      '{8'd1, '{vfr_pkg::OP_SET_VOLUME, 8'd20, 16'd0, 1'b0}, 1'b0, '0},
      // cancel a fade in: no stop request
      '{8'd1, '{vfr_pkg::OP_STOP_FADE, 8'd0, 16'd0, 1'b1}, 1'b0, '0},
      // longest duration clamps the interval high, cancel asks for a stop
      '{8'd1, '{vfr_pkg::OP_FADE_OUT, 8'd18, 16'hffff, 1'b1}, 1'b0, '0},
      '{8'd1, '{vfr_pkg::OP_STOP_FADE, 8'd0, 16'd0, 1'b1}, 1'b0, '0},
      '{8'd1, '{vfr_pkg::OP_FADE_TO, 8'd255, 16'd7, 1'b0}, 1'b0, '0}
   };

   // csr settings and idling of each random phase
   typedef struct packed {
      logic [vfr_pkg::LEVEL_BITS-1:0]    vol_min;
      logic [vfr_pkg::LEVEL_BITS-1:0]    vol_max;
      logic [vfr_pkg::DURATION_BITS-1:0] fade_floor;
      int                                send_idle;
      int                                recv_stall;
      logic                              long_fade;
   } phase_type;

   localparam int NUM_PHASES = 8;
   localparam phase_type PHASES [NUM_PHASES] = '{
      '{8'd0,   8'd255, 16'd0,     0,  0,  1'b0},  // full range, no idling
      '{8'd5,   8'd40,  16'd100,   82, 0,  1'b0},  // sender mostly idle
      '{8'd0,   8'd30,  16'd0,     0,  82, 1'b0},  // receiver mostly stalled
      '{8'd200, 8'd255, 16'd20,    15, 15, 1'b0},  // high window, light idling
      '{8'd20,  8'd10,  16'd50,    82, 0,  1'b0},  // crossed limits
      '{8'd0,   8'd255, 16'd65535, 0,  0,  1'b1},  // longest fade floor
      '{8'd255, 8'd255, 16'd1000,  0,  82, 1'b0},  // pinned at the top
      '{8'd0,   8'd0,   16'd10,    15, 15, 1'b0}   // pinned at zero
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                              req_valid = 1'b0;
   logic                              req_ready;
   vfr_pkg::req_type                  req_data  = '0;
   logic                              rsp_valid;
   logic                              rsp_ready = 1'b0;
   vfr_pkg::rsp_type                  rsp_data;
   logic                              csr_valid = 1'b0;
   logic                              csr_ready;
   logic [vfr_pkg::CSR_IDX_BITS-1:0]  csr_index = '0;
   logic [vfr_pkg::DURATION_BITS-1:0] csr_data  = '0;

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int items_sent     = 0;
   int fail_count     = 0;

   vfr_pkg::rsp_type expected_status_q[$];

   // model copy of the csrs
   logic [vfr_pkg::LEVEL_BITS-1:0]    lim_lo        = vfr_pkg::VOLUME_MIN_RST;
   logic [vfr_pkg::LEVEL_BITS-1:0]    lim_hi        = vfr_pkg::VOLUME_MAX_RST;
   logic [vfr_pkg::DURATION_BITS-1:0] fade_floor_ms = vfr_pkg::FADE_MIN_RST;

   // model copy of the ramp state
   logic [vfr_pkg::LEVEL_BITS-1:0] vol_now    = '0;
   logic [vfr_pkg::LEVEL_BITS-1:0] vol_goal   = '0;
   logic [vfr_pkg::DIR_BITS-1:0]   fade_dir   = vfr_pkg::FADE_NONE;
   logic [vfr_pkg::COUNT_BITS-1:0] step_len   = '0;
   logic [vfr_pkg::COUNT_BITS-1:0] step_count = '0;
   logic                           stop_armed = 1'b0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   volume_fade_ramp_top u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // floor test first, so crossed limits give the floor below it, the ceiling above
   function automatic logic [vfr_pkg::LEVEL_BITS-1:0] fit_level(input int unsigned x);
      if (x < lim_lo) begin
         return lim_lo;
      end
      if (x > lim_hi) begin
         return lim_hi;
      end
      return vfr_pkg::LEVEL_BITS'(x);
   endfunction

   // step interval from duration and level distance; a zero distance starts nothing
   function automatic void begin_fade(input logic [vfr_pkg::DIR_BITS-1:0] dir,
                                      input int unsigned dur);
      int unsigned gap;
      int unsigned span;
      gap = (vol_goal > vol_now) ? vol_goal - vol_now : vol_now - vol_goal;
      if (gap == 0) begin
         return;
      end
      span = (dur < fade_floor_ms) ? fade_floor_ms : dur;
      span = span / gap;
      if (span < vfr_pkg::INTERVAL_LO) begin
         span = vfr_pkg::INTERVAL_LO;
      end
      if (span > vfr_pkg::INTERVAL_HI) begin
         span = vfr_pkg::INTERVAL_HI;
      end
      step_len   = vfr_pkg::COUNT_BITS'(span);
      step_count = '0;
      fade_dir   = dir;
   endfunction

   // apply one command to the model state and return the response it gives
   function automatic vfr_pkg::rsp_type predict_fade(input vfr_pkg::req_type cmd);
      vfr_pkg::rsp_type               r;
      logic [vfr_pkg::LEVEL_BITS-1:0] prior;
      int unsigned                    nv;
      r     = '0;
      prior = vol_now;
      case (cmd.op)
         vfr_pkg::OP_TICK: begin
            if (fade_dir != vfr_pkg::FADE_NONE) begin
               if (step_count < vfr_pkg::COUNT_MAX) begin
                  step_count++;
               end
               if (step_count >= step_len) begin
                  step_count = '0;
                  nv = vol_now;
                  if (fade_dir == vfr_pkg::FADE_IN) begin
                     nv = vol_now + 1;
                     if (nv > vol_goal) begin
                        nv = vol_goal;
                     end
                  end else if (fade_dir == vfr_pkg::FADE_OUT) begin
                     nv = (vol_now > 0) ? vol_now - 1 : 0;
                     if (vol_now == 0 || nv < vol_goal) begin
                        nv = vol_goal;
                     end
                  end
                  vol_now = fit_level(nv);
                  if (vol_now == vol_goal) begin
                     if (fade_dir == vfr_pkg::FADE_OUT && stop_armed) begin
                        r.stop_request = 1'b1;
                        stop_armed     = 1'b0;
                     end
                     fade_dir = vfr_pkg::FADE_NONE;
                  end
               end
            end
         end
         vfr_pkg::OP_SET_VOLUME: begin
            vol_now = fit_level(cmd.level);
         end
         vfr_pkg::OP_FADE_IN: begin
            vol_now        = fit_level(0);
            r.play_request = 1'b1;
            if (fade_dir == vfr_pkg::FADE_NONE) begin
               vol_goal = fit_level(cmd.level);
               begin_fade(vfr_pkg::FADE_IN, cmd.duration_ms);
            end else begin
               r.ignored = 1'b1;
            end
         end
         vfr_pkg::OP_FADE_OUT: begin
            stop_armed = cmd.stop_sound;
            if (fade_dir == vfr_pkg::FADE_NONE) begin
               vol_now  = fit_level(vol_now);
               vol_goal = fit_level(cmd.level);
               if (vol_now > vol_goal) begin
                  begin_fade(vfr_pkg::FADE_OUT, cmd.duration_ms);
               end
            end else begin
               r.ignored = 1'b1;
            end
         end
         vfr_pkg::OP_FADE_TO: begin
            stop_armed = 1'b0;
            if (fade_dir == vfr_pkg::FADE_NONE) begin
               vol_now  = fit_level(vol_now);
               vol_goal = fit_level(cmd.level);
               if (vol_now < vol_goal) begin
                  begin_fade(vfr_pkg::FADE_IN, cmd.duration_ms);
               end else if (vol_now > vol_goal) begin
                  begin_fade(vfr_pkg::FADE_OUT, cmd.duration_ms);
               end
            end else begin
               r.ignored = 1'b1;
            end
         end
         vfr_pkg::OP_STOP_FADE: begin
            if (fade_dir != vfr_pkg::FADE_NONE) begin
               if (fade_dir == vfr_pkg::FADE_OUT && cmd.stop_sound) begin
                  r.stop_request = 1'b1;
               end
               fade_dir   = vfr_pkg::FADE_NONE;
               step_len   = '0;
               step_count = '0;
               stop_armed = 1'b0;
            end
         end
         default: begin
         end
      endcase
      r.volume         = vol_now;
      r.volume_changed = (vol_now != prior);
      r.direction      = fade_dir;
      return r;
   endfunction

   // offer one item, with random idle cycles ahead of it; valid stays up after
   // acceptance so the next item can follow back to back
   task automatic send_cmd(input vfr_pkg::req_type cmd, input logic typed,
                           input vfr_pkg::rsp_type typed_result);
      vfr_pkg::rsp_type want;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= cmd;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
      want = predict_fade(cmd);
      if (typed) begin
         want = typed_result;
      end
      expected_status_q.push_back(want);
      items_sent++;
   endtask

   // one csr write; the caller lowers csr_valid after its last write
   task automatic write_csr(input logic [vfr_pkg::CSR_IDX_BITS-1:0] idx,
                            input logic [vfr_pkg::DURATION_BITS-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) begin
         @(posedge clock);
      end
      case (idx)
         vfr_pkg::CSR_VOLUME_MIN:  lim_lo        = val[vfr_pkg::LEVEL_BITS-1:0];
         vfr_pkg::CSR_VOLUME_MAX:  lim_hi        = val[vfr_pkg::LEVEL_BITS-1:0];
         vfr_pkg::CSR_FADE_MIN_MS: fade_floor_ms = val;
         default: begin
         end
      endcase
   endtask

   // wait for every outstanding result, then let a fade start run out
   task automatic settle();
      while (expected_status_q.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // response side: check each accepted item, then pick the next ready value
   always @(posedge clock) begin : result_check
      vfr_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_status_q.size() == 0) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS) begin
               $display("unexpected result item at %0t:", $realtime);
               $display("  got vol=%0d chg=%0b dir=%0d stop=%0b play=%0b ign=%0b",
                        rsp_data.volume, rsp_data.volume_changed,
                        rsp_data.direction, rsp_data.stop_request,
                        rsp_data.play_request, rsp_data.ignored);
            end
         end else begin
            want = expected_status_q.pop_front();
            if (rsp_data.volume         !== want.volume         ||
                rsp_data.volume_changed !== want.volume_changed ||
                rsp_data.direction      !== want.direction      ||
                rsp_data.stop_request   !== want.stop_request   ||
                rsp_data.play_request   !== want.play_request   ||
                rsp_data.ignored        !== want.ignored) begin
               fail_count++;
               if (fail_count <= MAX_REPORTS) begin
                  $display("result mismatch at %0t:", $realtime);
                  $display("  exp vol=%0d chg=%0b dir=%0d stop=%0b play=%0b ign=%0b",
                           want.volume, want.volume_changed, want.direction,
                           want.stop_request, want.play_request, want.ignored);
                  $display("  got vol=%0d chg=%0b dir=%0d stop=%0b play=%0b ign=%0b",
                           rsp_data.volume, rsp_data.volume_changed, rsp_data.direction,
                           rsp_data.stop_request, rsp_data.play_request, rsp_data.ignored);
               end
            end
         end
      end
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   initial begin : stimulus
      vfr_pkg::req_type cmd;
      int               pick;
      int               lvl;
      int               gap;
      int               n;
      int               mark;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table under the reset csr values
      for (int i = 0; i < SCRIPT_LEN; i++) begin
         for (int k = 0; k < SCRIPT[i].count; k++) begin
            send_cmd(SCRIPT[i].cmd, SCRIPT[i].typed, SCRIPT[i].result);
         end
      end

      for (int p = 0; p < NUM_PHASES; p++) begin
         // cancel any running fade so it cannot hang under the new limits
         cmd    = '0;
         cmd.op = vfr_pkg::OP_STOP_FADE;
         send_cmd(cmd, 1'b0, '0);
         req_valid <= 1'b0;
         settle();

         send_idle_pct  = PHASES[p].send_idle;
         recv_stall_pct = PHASES[p].recv_stall;
         // upper data bits are junk for the level registers
         write_csr(vfr_pkg::CSR_VOLUME_MIN, {8'($urandom), PHASES[p].vol_min});
         write_csr(vfr_pkg::CSR_VOLUME_MAX, {8'($urandom), PHASES[p].vol_max});
         write_csr(vfr_pkg::CSR_FADE_MIN_MS, PHASES[p].fade_floor);
         csr_valid <= 1'b0;

         // one step at the longest interval, run to completion
         if (PHASES[p].long_fade) begin
            cmd       = '0;
            cmd.op    = vfr_pkg::OP_SET_VOLUME;
            cmd.level = 8'd100;
            send_cmd(cmd, 1'b0, '0);
            cmd.op    = vfr_pkg::OP_FADE_TO;
            cmd.level = 8'd101;
            send_cmd(cmd, 1'b0, '0);
            cmd = '0;
            repeat (LONG_TICKS) send_cmd(cmd, 1'b0, '0);
         end

         mark = items_sent;
         while (items_sent - mark < PHASE_ITEMS) begin
            cmd  = '0;
            pick = $urandom_range(99);
            if (pick < 12) begin
               // raw noise, spare codes included
               cmd = vfr_pkg::req_type'($urandom);
               send_cmd(cmd, 1'b0, '0);
            end else if (pick < 22) begin
               cmd.op    = vfr_pkg::OP_SET_VOLUME;
               cmd.level = 8'($urandom);
               send_cmd(cmd, 1'b0, '0);
            end else if (pick < 30) begin
               cmd.op         = vfr_pkg::OP_STOP_FADE;
               cmd.stop_sound = 1'($urandom);
               send_cmd(cmd, 1'b0, '0);
            end else begin
               // fade request aimed a few levels from where the volume will start
               if (pick < 55) begin
                  cmd.op = vfr_pkg::OP_FADE_TO;
               end else if (pick < 78) begin
                  cmd.op = vfr_pkg::OP_FADE_OUT;
               end else begin
                  cmd.op = vfr_pkg::OP_FADE_IN;
               end
               lvl = (cmd.op == vfr_pkg::OP_FADE_IN) ? int'(fit_level(0)) : int'(vol_now);
               if (cmd.op == vfr_pkg::OP_FADE_OUT) begin
                  lvl = lvl - int'($urandom_range(4));
               end else if (cmd.op == vfr_pkg::OP_FADE_IN) begin
                  lvl = lvl + int'($urandom_range(4));
               end else begin
                  lvl = lvl + int'($urandom_range(8)) - 4;
               end
               if (lvl < 0) begin
                  lvl = 0;
               end
               if (lvl > 255) begin
                  lvl = 255;
               end
               cmd.level = 8'(lvl);
               if ($urandom_range(5) == 0) begin
                  cmd.level = 8'($urandom);
               end
               cmd.duration_ms = ($urandom_range(3) == 0) ? 16'($urandom)
                                                          : 16'($urandom_range(60));
               cmd.stop_sound  = 1'($urandom);
               send_cmd(cmd, 1'b0, '0);

               // enough ticks to finish the fade, with the odd stray command
               n = $urandom_range(3);
               if (fade_dir != vfr_pkg::FADE_NONE) begin
                  gap = (vol_goal > vol_now) ? vol_goal - vol_now : vol_now - vol_goal;
                  n   = n + int'(step_len) * gap;
               end
               if (n > TICK_CAP) begin
                  n = TICK_CAP;
               end
               for (int t = 0; t < n; t++) begin
                  cmd = '0;
                  if ($urandom_range(29) == 0) begin
                     cmd.op          = vfr_pkg::OP_SET_VOLUME + 3'($urandom_range(3));
                     cmd.level       = 8'($urandom);
                     cmd.duration_ms = 16'($urandom);
                     cmd.stop_sound  = 1'($urandom);
                  end
                  send_cmd(cmd, 1'b0, '0);
               end
            end
         end
      end

      req_valid <= 1'b0;
      settle();
      if (fail_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // hard stop well beyond the slowest correct run
   initial begin : watchdog
      #5_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
